/* rtl/esc_pkg.sv */
// shared types, constants and register indexes for the environmental sensor compensation
package esc_pkg;

  typedef struct packed {
    logic [19:0] adc_press;
    logic [19:0] adc_temp;
    logic [15:0] adc_hum;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] temp_x100;
    logic        [23:0] pressure;
    logic        [13:0] humidity;
  } out_t;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MISC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED  = 3'd5;

  localparam int MUL_LAT = 2;
  localparam int DIV_W   = 64;
  localparam int DIV_LAT = DIV_W + 2;

  localparam logic signed [63:0] P_OFS     = 64'sd128000;
  localparam logic        [20:0] P_BASE    = 21'd1048576;
  localparam logic        [63:0] P_SCALE   = 64'd3125;
  localparam logic signed [63:0] P_ONE47   = 64'sd140737488355328;
  localparam logic signed [31:0] H_OFS     = 32'sd76800;
  localparam logic signed [31:0] H_RND     = 32'sd16384;
  localparam logic signed [31:0] H_BIAS    = 32'sd2097152;
  localparam logic signed [31:0] H_RND2    = 32'sd8192;
  localparam logic signed [31:0] H_HALF    = 32'sd32768;
  localparam logic signed [31:0] H_MAX     = 32'sd419430400;
  localparam logic        [13:0] HUM_MAX   = 14'd10000;
  localparam logic        [23:0] PRESS_MAX = 24'hFFFFFF;

endpackage

/* rtl/esc_dly.sv */
// fixed-length delay line for data that rides alongside the pipeline
module esc_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [N];

  always_ff @(posedge clk) begin
    pipe[0] <= d;
    for (int i = 1; i < N; i++) begin
      pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[N-1];

endmodule

/* rtl/esc_mul64.sv */
// two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 partial products
module esc_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;
  logic [31:0] mid;

  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= 32'(a[31:0] * b[63:32]);
    hl <= 32'(a[63:32] * b[31:0]);
  end

  assign mid = lh + hl;

  always_ff @(posedge clk) begin
    p <= ll + {mid, 32'd0};
  end

endmodule

/* rtl/esc_div64.sv */
// pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero
module esc_div64 (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo,
  output logic        dz
);

  localparam int W = esc_pkg::DIV_W;

  logic [W-1:0] rem  [W+1];
  logic [W-1:0] dvd  [W+1];
  logic [W-1:0] dsr  [W+1];
  logic         neg  [W+1];
  logic         zero [W+1];

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    rem[0]  <= '0;
    dvd[0]  <= num[W-1] ? (W'(0) - num) : num;
    dsr[0]  <= den[W-1] ? (W'(0) - den) : den;
    neg[0]  <= num[W-1] ^ den[W-1];
    zero[0] <= (den == '0);
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] trial;
    logic       fits;
    assign trial = {rem[i], dvd[i][W-1]};
    assign fits  = (trial >= {1'b0, dsr[i]});
    always_ff @(posedge clk) begin
      rem[i+1]  <= fits ? W'(trial - {1'b0, dsr[i]}) : trial[W-1:0];
      dvd[i+1]  <= {dvd[i][W-2:0], fits};
      dsr[i+1]  <= dsr[i];
      neg[i+1]  <= neg[i];
      zero[i+1] <= zero[i];
    end
  end

  always_ff @(posedge clk) begin
    quo <= neg[W] ? (W'(0) - dvd[W]) : dvd[W];
    dz  <= zero[W];
  end

endmodule

/* rtl/env_sensor_compensation.sv */
// throughput: one item per cycle, start is taken in every cycle that busy is low
// the pressure divide is a 64-stage pipeline, one quotient bit per stage, and sets the depth
// rst clears the valid chain, the trim registers and the calibrated flag; busy is high in reset
// results go out on done for one cycle and cannot be held off
module env_sensor_compensation (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  esc_pkg::in_t                 item,
  output logic                         done,
  output esc_pkg::out_t                result,
  input  logic                         cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [esc_pkg::CFG_W-1:0]    cfg_data
);

  localparam int ML    = esc_pkg::MUL_LAT;
  localparam int S_X1  = 5;
  localparam int S_SQ  = S_X1 + ML;
  localparam int S_X2A = S_SQ + ML;
  localparam int S_C   = S_X2A + 1;
  localparam int S_NM  = S_C + 1;
  localparam int S_PR  = S_C + ML;
  localparam int S_NUM = S_NM + ML;
  localparam int S_DIV = S_NUM + esc_pkg::DIV_LAT;
  localparam int S_QQ  = S_DIV + ML;
  localparam int S_Y1  = S_QQ + ML;
  localparam int S_SUM = S_Y1 + 1;
  localparam int S_R   = S_SUM + 1;
  localparam int S_HUM = S_X1 + 8;
  localparam int LAT   = S_R + 1;

  // configuration
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [47:0] cal_misc;
  logic [39:0] cal_hum;
  logic        calibrated;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_misc    <= '0;
      cal_hum     <= '0;
      calibrated  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        esc_pkg::REG_CAL_TEMP:    cal_temp    <= cfg_data[47:0];
        esc_pkg::REG_CAL_PRESS_A: cal_press_a <= cfg_data;
        esc_pkg::REG_CAL_PRESS_B: cal_press_b <= cfg_data;
        esc_pkg::REG_CAL_MISC:    cal_misc    <= cfg_data[47:0];
        esc_pkg::REG_CAL_HUM:     cal_hum     <= cfg_data[39:0];
        esc_pkg::REG_CALIBRATED:  calibrated  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // trim words
  logic signed [31:0] t1, t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = $signed({16'd0, cal_temp[15:0]});
  assign t2 = 32'(signed'(cal_temp[31:16]));
  assign t3 = 32'(signed'(cal_temp[47:32]));
  assign p1 = $signed({48'd0, cal_press_a[15:0]});
  assign p2 = 64'(signed'(cal_press_a[31:16]));
  assign p3 = 64'(signed'(cal_press_a[47:32]));
  assign p4 = 64'(signed'(cal_press_a[63:48]));
  assign p5 = 64'(signed'(cal_press_b[15:0]));
  assign p6 = 64'(signed'(cal_press_b[31:16]));
  assign p7 = 64'(signed'(cal_press_b[47:32]));
  assign p8 = 64'(signed'(cal_press_b[63:48]));
  assign p9 = 64'(signed'(cal_misc[15:0]));
  assign h1 = $signed({24'd0, cal_misc[23:16]});
  assign h2 = 32'(signed'(cal_misc[39:24]));
  assign h3 = $signed({24'd0, cal_misc[47:40]});
  assign h4 = 32'(signed'(cal_hum[15:0]));
  assign h5 = 32'(signed'(cal_hum[31:16]));
  assign h6 = 32'(signed'(cal_hum[39:32]));

  // handshake and valid chain
  logic           accept;
  logic [LAT-1:0] vld;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], accept};
    end
  end

  esc_pkg::in_t in_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= item;
    end
  end

  // temperature
  logic signed [31:0] ta, dd, v1, v2p, tf, tx5, hv;
  logic signed [63:0] x1;
  logic signed [31:0] at3, at4;

  assign at3 = $signed({15'd0, in_r.adc_temp[19:3]});
  assign at4 = $signed({16'd0, in_r.adc_temp[19:4]});

  always_ff @(posedge clk) begin
    ta  <= (at3 - (t1 <<< 1)) * t2;
    dd  <= (at4 - t1) * (at4 - t1);
    v1  <= ta >>> 11;
    v2p <= (dd >>> 12) * t3;
    tf  <= v1 + (v2p >>> 14);
    tx5 <= ((tf <<< 2) + tf + 32'sd128) >>> 8;
    x1  <= 64'(tf) - esc_pkg::P_OFS;
    hv  <= tf - esc_pkg::H_OFS;
  end

  // pressure, front part
  logic [63:0] sq, m5, m2, x2a, x1a, m5d, m2d, prod, prod_d, num;
  logic signed [63:0] x2, x1s, nm, den;
  logic [19:0] ap_d;

  esc_mul64 u_mul_sq (.clk(clk), .a(x1), .b(x1), .p(sq));
  esc_mul64 u_mul_m5 (.clk(clk), .a(x1), .b(p5), .p(m5));
  esc_mul64 u_mul_m2 (.clk(clk), .a(x1), .b(p2), .p(m2));
  esc_mul64 u_mul_x2 (.clk(clk), .a(sq), .b(p6), .p(x2a));
  esc_mul64 u_mul_x1 (.clk(clk), .a(sq), .b(p3), .p(x1a));

  esc_dly #(.W(64), .N(ML)) u_dly_m5 (.clk(clk), .d(m5), .q(m5d));
  esc_dly #(.W(64), .N(ML)) u_dly_m2 (.clk(clk), .d(m2), .q(m2d));
  esc_dly #(.W(20), .N(S_C - 1)) u_dly_ap (.clk(clk), .d(in_r.adc_press), .q(ap_d));

  always_ff @(posedge clk) begin
    x2  <= $signed(x2a) + $signed(m5d << 17) + (p4 <<< 35);
    x1s <= esc_pkg::P_ONE47 + ($signed(x1a) >>> 8) + $signed(m2d << 12);
    nm  <= $signed({43'd0, esc_pkg::P_BASE - {1'b0, ap_d}} << 31) - x2;
  end

  esc_mul64 u_mul_p1  (.clk(clk), .a(x1s), .b(p1), .p(prod));
  esc_mul64 u_mul_num (.clk(clk), .a(nm), .b(esc_pkg::P_SCALE), .p(num));
  esc_dly #(.W(64), .N(S_NUM - S_PR)) u_dly_pr (.clk(clk), .d(prod), .q(prod_d));

  assign den = $signed(prod_d) >>> 33;

  // divide
  logic [63:0] quo, qq, y2, y1r, y2d, pd1, pd2;
  logic signed [63:0] qs, sum, r;
  logic dz, dz_d;

  esc_div64 u_div (.clk(clk), .num(num), .den(den), .quo(quo), .dz(dz));

  // pressure, back part
  assign qs = $signed(quo) >>> 13;

  esc_mul64 u_mul_qq (.clk(clk), .a(qs), .b(qs), .p(qq));
  esc_mul64 u_mul_y2 (.clk(clk), .a(quo), .b(p8), .p(y2));
  esc_mul64 u_mul_y1 (.clk(clk), .a(qq), .b(p9), .p(y1r));
  esc_dly #(.W(64), .N(ML)) u_dly_p1 (.clk(clk), .d(quo), .q(pd1));
  esc_dly #(.W(64), .N(ML)) u_dly_p2 (.clk(clk), .d(pd1), .q(pd2));
  esc_dly #(.W(64), .N(ML)) u_dly_y2 (.clk(clk), .d(y2), .q(y2d));
  esc_dly #(.W(1), .N(S_R - S_DIV)) u_dly_dz (.clk(clk), .d(dz), .q(dz_d));

  always_ff @(posedge clk) begin
    sum <= $signed(pd2) + ($signed(y1r) >>> 25) + ($signed(y2d) >>> 19);
    r   <= (sum >>> 8) + (p7 <<< 4);
  end

  logic signed [63:0] pr;
  logic [23:0] pa;

  assign pr = r >>> 8;

  always_comb begin
    if (dz_d || pr[63]) begin
      pa = '0;
    end else if (pr > $signed({40'd0, esc_pkg::PRESS_MAX})) begin
      pa = esc_pkg::PRESS_MAX;
    end else begin
      pa = pr[23:0];
    end
  end

  // humidity
  logic [15:0] ah_d;
  logic signed [31:0] lhs_p, a6, a3, lhs, inner, lhs2, rhs_p, hp, hp2, hp3, ss, th, hvs;
  logic [28:0] hvc;
  logic [23:0] hmul;
  logic [13:0] hx, hum_d;

  esc_dly #(.W(16), .N(S_X1 - 1)) u_dly_ah (.clk(clk), .d(in_r.adc_hum), .q(ah_d));

  assign hvs  = hp3 - (th >>> 4);
  assign hmul = 24'(hvc[28:12]) * 24'd100;

  always_ff @(posedge clk) begin
    lhs_p <= $signed({2'd0, ah_d, 14'd0}) - (h4 <<< 20) - h5 * hv + esc_pkg::H_RND;
    a6    <= hv * h6;
    a3    <= hv * h3;
    lhs   <= lhs_p >>> 15;
    inner <= (a6 >>> 10) * ((a3 >>> 11) + esc_pkg::H_HALF);
    lhs2  <= lhs;
    rhs_p <= ((inner >>> 10) + esc_pkg::H_BIAS) * h2 + esc_pkg::H_RND2;
    hp    <= lhs2 * (rhs_p >>> 14);
    ss    <= (hp >>> 15) * (hp >>> 15);
    hp2   <= hp;
    th    <= (ss >>> 7) * h1;
    hp3   <= hp2;
    if (hvs[31]) begin
      hvc <= '0;
    end else if (hvs > esc_pkg::H_MAX) begin
      hvc <= esc_pkg::H_MAX[28:0];
    end else begin
      hvc <= hvs[28:0];
    end
    hx <= (hmul[23:10] > esc_pkg::HUM_MAX) ? esc_pkg::HUM_MAX : hmul[23:10];
  end

  esc_dly #(.W(14), .N(S_R - S_HUM)) u_dly_hum (.clk(clk), .d(hx), .q(hum_d));

  logic [15:0] tx_d;

  esc_dly #(.W(16), .N(S_R - S_X1)) u_dly_tx (.clk(clk), .d(tx5[15:0]), .q(tx_d));

  // result register
  always_ff @(posedge clk) begin
    result.ok        <= calibrated;
    result.temp_x100 <= calibrated ? $signed(tx_d) : 16'sd0;
    result.pressure  <= calibrated ? pa : '0;
    result.humidity  <= calibrated ? hum_d : '0;
  end

  assign done = vld[LAT-1];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");
  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
      done && !result.ok |-> result.temp_x100 == 16'sd0 && result.pressure == 24'd0 &&
                             result.humidity == 14'd0)
    else $error("uncalibrated result not zero");
  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
      done |-> result.humidity <= esc_pkg::HUM_MAX)
    else $error("humidity above clamp");
  a_latency: assert property (@(posedge clk) disable iff (rst)
      accept |-> ##(LAT) done)
    else $error("transfer lost in pipeline");

endmodule

/* tb/env_sensor_compensation_checker.sv */
// checker for env_sensor_compensation: tracks trim registers, predicts readings, compares
`timescale 1ns / 1ps
module env_sensor_compensation_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  esc_pkg::in_t                  item,
  input  logic                          done,
  input  esc_pkg::out_t                 result,
  input  logic                          cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [esc_pkg::CFG_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);

  logic [47:0] trim_temp;
  logic [63:0] trim_press_a;
  logic [63:0] trim_press_b;
  logic [47:0] trim_misc;
  logic [39:0] trim_hum;
  logic        trim_valid;

  esc_pkg::out_t expected_readings[$];

  assign pending = expected_readings.size();

  function automatic logic [31:0] asr32(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sx64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // signed divide, truncating toward zero; most negative over -1 wraps to itself
  function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic esc_pkg::out_t predict_reading(esc_pkg::in_t x);
    esc_pkg::out_t r;
    logic [31:0] at, ah, t1, t2, t3, a, d, v1, v2, tf, tx;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, lhs, inner, rhs, s, hq, hx;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, p, q, y1, y2, pa;
    r = '0;
    if (!trim_valid) return r;

    at = {12'd0, x.adc_temp};
    ah = {16'd0, x.adc_hum};
    t1 = {16'd0, trim_temp[15:0]};
    t2 = {{16{trim_temp[31]}}, trim_temp[31:16]};
    t3 = {{16{trim_temp[47]}}, trim_temp[47:32]};
    a  = ((at >> 3) - (t1 << 1)) * t2;
    v1 = asr32(a, 11);
    d  = (at >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    tx = asr32(tf * 32'd5 + 32'd128, 8);

    p1 = {48'd0, trim_press_a[15:0]};
    p2 = sx64(trim_press_a[31:16]);
    p3 = sx64(trim_press_a[47:32]);
    p4 = sx64(trim_press_a[63:48]);
    p5 = sx64(trim_press_b[15:0]);
    p6 = sx64(trim_press_b[31:16]);
    p7 = sx64(trim_press_b[47:32]);
    p8 = sx64(trim_press_b[63:48]);
    p9 = sx64(trim_misc[15:0]);
    x1 = {{32{tf[31]}}, tf} - esc_pkg::P_OFS;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) << 17);
    x2 = x2 + (p4 << 35);
    x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
    x1 = asr64((esc_pkg::P_ONE47 + x1) * p1, 33);
    pa = '0;
    if (x1 != 64'd0) begin
      p  = {43'd0, esc_pkg::P_BASE} - {44'd0, x.adc_press};
      p  = div_trunc(((p << 31) - x2) * esc_pkg::P_SCALE, x1);
      q  = asr64(p, 13);
      y1 = asr64(p9 * q * q, 25);
      y2 = asr64(p8 * p, 19);
      p  = asr64(p + y1 + y2, 8) + (p7 << 4);
      p  = asr64(p, 8);
      if (p[63]) pa = '0;
      else if (p > 64'hFFFFFF) pa = 64'hFFFFFF;
      else pa = p;
    end

    h1 = {24'd0, trim_misc[23:16]};
    h2 = {{16{trim_misc[39]}}, trim_misc[39:24]};
    h3 = {24'd0, trim_misc[47:40]};
    h4 = {{16{trim_hum[15]}}, trim_hum[15:0]};
    h5 = {{16{trim_hum[31]}}, trim_hum[31:16]};
    h6 = {{24{trim_hum[39]}}, trim_hum[39:32]};
    v     = tf - esc_pkg::H_OFS;
    lhs   = asr32((ah << 14) - (h4 << 20) - h5 * v + esc_pkg::H_RND, 15);
    inner = asr32(v * h6, 10) * (asr32(v * h3, 11) + esc_pkg::H_HALF);
    rhs   = asr32((asr32(inner, 10) + esc_pkg::H_BIAS) * h2 + esc_pkg::H_RND2, 14);
    v     = lhs * rhs;
    s     = asr32(v, 15);
    v     = v - asr32(asr32(s * s, 7) * h1, 4);
    if (v[31]) v = '0;
    else if (v > esc_pkg::H_MAX) v = esc_pkg::H_MAX;
    hq = v >> 12;
    hx = (hq * 32'd100) / 32'd1024;
    if (hx > 32'd10000) hx = 32'd10000;

    r.ok        = 1'b1;
    r.temp_x100 = tx[15:0];
    r.pressure  = pa[23:0];
    r.humidity  = hx[13:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    esc_pkg::out_t want;
    if (rst) begin
      trim_temp    <= '0;
      trim_press_a <= '0;
      trim_press_b <= '0;
      trim_misc    <= '0;
      trim_hum     <= '0;
      trim_valid   <= 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          esc_pkg::REG_CAL_TEMP:    trim_temp    <= cfg_data[47:0];
          esc_pkg::REG_CAL_PRESS_A: trim_press_a <= cfg_data;
          esc_pkg::REG_CAL_PRESS_B: trim_press_b <= cfg_data;
          esc_pkg::REG_CAL_MISC:    trim_misc    <= cfg_data[47:0];
          esc_pkg::REG_CAL_HUM:     trim_hum     <= cfg_data[39:0];
          esc_pkg::REG_CALIBRATED:  trim_valid   <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) expected_readings.push_back(predict_reading(item));
      if (done) begin
        if (expected_readings.size() == 0) begin
          report("unexpected transfer", 64'(result), '0);
        end else begin
          want = expected_readings.pop_front();
          if (result.ok !== want.ok) report("ok", 64'(result.ok), 64'(want.ok));
          if (result.temp_x100 !== want.temp_x100)
            report("temp_x100", 64'(result.temp_x100), 64'(want.temp_x100));
          if (result.pressure !== want.pressure)
            report("pressure", 64'(result.pressure), 64'(want.pressure));
          if (result.humidity !== want.humidity)
            report("humidity", 64'(result.humidity), 64'(want.humidity));
        end
      end
    end
  end

endmodule

/* tb/tb_env_sensor_compensation.sv */
// testbench top for env_sensor_compensation: stimulus, trim settings and verdict
`timescale 1ns / 1ps
module tb_env_sensor_compensation;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN       = 120;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  esc_pkg::in_t                  item;
  logic                          done;
  esc_pkg::out_t                 result;
  logic                          cfg_we;
  logic [esc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [esc_pkg::CFG_W-1:0]     cfg_data;
  int                            errors;
  int                            pending;
  int                            cycles;

  env_sensor_compensation dut (
    .clk, .rst, .start, .busy, .item, .done, .result, .cfg_we, .cfg_idx, .cfg_data
  );

  env_sensor_compensation_checker u_checker (
    .clk, .rst, .start, .busy, .item, .done, .result, .cfg_we, .cfg_idx, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("env_sensor_compensation verification failed");
      $finish;
    end
  end

  // cfg_we stays high for back-to-back writes, the caller drops it after the last one
  task automatic write_reg(logic [esc_pkg::CFG_IDX_W-1:0] idx,
                           logic [esc_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_trim(logic [47:0] tw, logic [63:0] pa, logic [63:0] pb,
                           logic [47:0] mw, logic [39:0] hw, logic valid);
    write_reg(esc_pkg::REG_CAL_TEMP, {16'd0, tw});
    write_reg(esc_pkg::REG_CAL_PRESS_A, pa);
    write_reg(esc_pkg::REG_CAL_PRESS_B, pb);
    write_reg(esc_pkg::REG_CAL_MISC, {16'd0, mw});
    write_reg(esc_pkg::REG_CAL_HUM, {24'd0, hw});
    write_reg(esc_pkg::REG_CALIBRATED, {63'd0, valid});
    cfg_we <= 1'b0;
  endtask

  // start is left high after a transfer so a back-to-back item keeps it up
  task automatic send(esc_pkg::in_t x);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= x;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic esc_pkg::in_t rand_reading();
    esc_pkg::in_t x;
    x.adc_press = 20'($urandom);
    x.adc_temp  = 20'($urandom);
    x.adc_hum   = 16'($urandom);
    // mostly readings around room conditions, the rest full range
    if ($urandom_range(0, 3) != 0) begin
      x.adc_press = 20'($urandom_range(200000, 500000));
      x.adc_temp  = 20'($urandom_range(400000, 650000));
      x.adc_hum   = 16'($urandom_range(20000, 40000));
    end
    return x;
  endfunction

  task automatic directed_sweep();
    send('{20'd0, 20'd0, 16'd0});
    send('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    send('{20'hFFFFF, 20'd0, 16'd0});
    send('{20'd0, 20'hFFFFF, 16'hFFFF});
    send('{20'h80000, 20'h80000, 16'h8000});
    send('{20'h7FFFF, 20'h7FFFF, 16'h7FFF});
    send('{20'd415148, 20'd519888, 16'd30000});
    send('{20'd0, 20'd519888, 16'hFFFF});
    send('{20'hFFFFF, 20'd519888, 16'd0});
  endtask

  task automatic random_run(int n);
    repeat (n) send(rand_reading());
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // not calibrated after reset: every reading comes back zero
    directed_sweep();
    random_run(20);
    settle();

    // typical factory trim
    load_trim({-16'sd1000, 16'sd26435, 16'd27504},
              {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
              {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
              {8'd0, 16'sd362, 8'd75, 16'sd6000},
              {8'sd30, 16'sd50, 16'sd313}, 1'b1);
    directed_sweep();
    random_run(250);
    settle();

    // all-zero trim: pressure divisor is zero
    load_trim('0, '0, '0, '0, '0, 1'b1);
    directed_sweep();
    random_run(40);
    settle();

    // all-ones trim
    load_trim('1, '1, '1, '1, '1, 1'b1);
    directed_sweep();
    random_run(40);
    settle();

    // most negative signed fields
    load_trim({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h8000}},
              {8'hFF, 16'h8000, 8'hFF, 16'h8000}, {8'h80, 16'h8000, 16'h8000}, 1'b1);
    directed_sweep();
    random_run(40);
    settle();

    // random trim words
    repeat (5) begin
      load_trim(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                48'({$urandom, $urandom}), 40'({$urandom, $urandom}), 1'b1);
      random_run(50);
      settle();
    end

    // flag cleared again with trim still loaded
    write_reg(esc_pkg::REG_CALIBRATED, '0);
    cfg_we <= 1'b0;
    random_run(30);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("env_sensor_compensation verification clean");
    end else begin
      $display("env_sensor_compensation verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/esc_pkg.sv
rtl/esc_dly.sv
rtl/esc_mul64.sv
rtl/esc_div64.sv
rtl/env_sensor_compensation.sv
tb/env_sensor_compensation_checker.sv
tb/tb_env_sensor_compensation.sv
